// ===== hdl/dmtt_pkg.sv =====
// Package with action, status and run state codes and default sizes for the task table.
package dmtt_pkg;

  localparam int DEF_MAX_TASKS = 16;
  localparam int DEF_TIME_BITS = 16;
  localparam int ID_BITS = 15;

  localparam logic [2:0] ACT_REG      = 3'd0;
  localparam logic [2:0] ACT_REG_RM   = 3'd1;
  localparam logic [2:0] ACT_REMOVE   = 3'd2;
  localparam logic [2:0] ACT_YIELD    = 3'd3;
  localparam logic [2:0] ACT_WAKE     = 3'd4;
  localparam logic [2:0] ACT_DISPATCH = 3'd5;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_INVALID  = 3'd1;
  localparam logic [2:0] STAT_DUP      = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_FULL     = 3'd4;
  localparam logic [2:0] STAT_NOSCHED  = 3'd5;
  localparam logic [2:0] STAT_NOTHING  = 3'd6;

  localparam logic [1:0] RS_READY   = 2'd0;
  localparam logic [1:0] RS_RUNNING = 2'd1;
  localparam logic [1:0] RS_SLEEP   = 2'd2;

endpackage

// ===== hdl/dmtt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module dmtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/deadline_monotonic_task_table.sv =====
// Top level of the deadline-ordered task table with response-time admission test.
//
// Channel   Direction  Ports
// command   in         start, busy, action, task_id, task_period, task_deadline, task_cost
// result    out        done, status, switched, running_valid, running_id,
//                      preempted_valid, preempted_id
//
// Every action first scans the n used entries through the RAM read port, with a read and an evaluate state each.
// Remove and insert then move entries one by one; yield, wake and dispatch write at most two
// entries. Register runs the admission test, where each interference term takes a serial divide
// and a multiply, repeated until each response time converges or exceeds its deadline.
// Reset is synchronous and empties the table at once; the entry RAM needs no clearing.
// One result follows each item, on done for one cycle; the receiver cannot stall it.
module deadline_monotonic_task_table #(
  parameter int MAX_TASKS = dmtt_pkg::DEF_MAX_TASKS,
  parameter int TIME_BITS = dmtt_pkg::DEF_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [14:0] task_id,
  input  logic [15:0] task_period,
  input  logic [15:0] task_deadline,
  input  logic [15:0] task_cost,
  output logic        done,
  output logic [2:0]  status,
  output logic        switched,
  output logic        running_valid,
  output logic [14:0] running_id,
  output logic        preempted_valid,
  output logic [14:0] preempted_id
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TB = TIME_BITS;
  localparam int DW = TB + 1;
  localparam int KW = $clog2(DW + 1);
  localparam int IDB = dmtt_pkg::ID_BITS;
  localparam int EW = IDB + 3 * TB + 2;
  localparam int CO_LSB = 2;
  localparam int DL_LSB = 2 + TB;
  localparam int PE_LSB = 2 + 2 * TB;
  localparam int ID_LSB = 2 + 3 * TB;
  localparam logic [TB-1:0] TMAX = {TB{1'b1}};

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_SCANRD = 18'h00002,
    S_SCANEV = 18'h00004,
    S_DECIDE = 18'h00008,
    S_OIRD   = 18'h00010,
    S_OIEV   = 18'h00020,
    S_ITER   = 18'h00040,
    S_INRD   = 18'h00080,
    S_INEV   = 18'h00100,
    S_DIV    = 18'h00200,
    S_MUL    = 18'h00400,
    S_ACC    = 18'h00800,
    S_CHK    = 18'h01000,
    S_SHCHK  = 18'h02000,
    S_SHRD   = 18'h04000,
    S_SHWR   = 18'h08000,
    S_WRITE  = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  function automatic logic [TB-1:0] sat_in(input logic [15:0] x);
    logic [32:0] e;
    e = {17'd0, x};
    if (e > 33'(TMAX)) return TMAX;
    return e[TB-1:0];
  endfunction

  function automatic logic [TB-1:0] sat1(input logic [DW-1:0] x);
    if (x[DW-1]) return TMAX;
    return x[TB-1:0];
  endfunction

  function automatic logic [TB-1:0] sat2(input logic [2*TB:0] x);
    if (x[2*TB:TB] != '0) return TMAX;
    return x[TB-1:0];
  endfunction

  state_t state;
  logic [CW-1:0] n;
  logic cur_valid;
  logic [IW-1:0] cur_slot;
  logic [IDB-1:0] cur_ident;

  logic [2:0] act;
  logic [IDB-1:0] id;
  logic [15:0] per_raw, dl_raw;
  logic [EW-1:0] newent;

  logic [IW-1:0] idx, pos, fk, rk, sidx;
  logic found, posf, rf, sh_up;
  logic [EW-1:0] fdata, rkdata, curdata;

  logic [IW-1:0] oi, ij;
  logic [TB-1:0] ci, di, tt, run, intf, pj, cj;
  logic [TB-1:0] drem;
  logic [DW-1:0] dq;
  logic [KW-1:0] dcnt;
  logic [2*TB-1:0] prod;

  logic [IW-1:0] wa, wa2;
  logic [EW-1:0] wd, wd2;
  logic has2;

  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [EW-1:0] oient, inent;
  logic [TB-1:0] nt;
  logic chk_done;
  logic [TB-1:0] tn;
  logic [TB:0] trial;

  dmtt_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  always_comb begin
    ram_raddr = idx;
    case (state)
      S_OIRD: ram_raddr = (oi < pos) ? oi : oi - IW'(1);
      S_INRD: ram_raddr = (ij < pos) ? ij : ij - IW'(1);
      S_SHRD: ram_raddr = sh_up ? sidx - IW'(1) : sidx + IW'(1);
      default: ram_raddr = idx;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = wa;
    ram_wdata = wd;
    case (state)
      S_SHWR: begin
        ram_we = 1'b1;
        ram_waddr = sidx;
        ram_wdata = ram_rdata;
      end
      S_WRITE: begin
        ram_we = 1'b1;
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign oient = (oi == pos) ? newent : ram_rdata;
  assign inent = (ij == pos) ? newent : ram_rdata;
  assign nt = sat2((2*TB+1)'(intf) + (2*TB+1)'(ci));
  assign chk_done = (nt <= tt);
  assign tn = chk_done ? tt : nt;
  assign trial = {drem, dq[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      cur_valid <= 1'b0;
      cur_slot <= '0;
      cur_ident <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            act <= action;
            id <= task_id;
            per_raw <= task_period;
            dl_raw <= task_deadline;
            newent <= {task_id, sat_in(task_period), sat_in(task_deadline),
                       sat_in(task_cost), dmtt_pkg::RS_READY};
            found <= 1'b0;
            posf <= 1'b0;
            rf <= 1'b0;
            idx <= '0;
            status <= dmtt_pkg::STAT_OK;
            switched <= 1'b0;
            preempted_valid <= 1'b0;
            preempted_id <= '0;
            has2 <= 1'b0;
            state <= (n == '0) ? S_DECIDE : S_SCANRD;
          end
        end
        S_SCANRD: state <= S_SCANEV;
        S_SCANEV: begin
          if (!found && ram_rdata[ID_LSB +: IDB] == id) begin
            found <= 1'b1;
            fk <= idx;
            fdata <= ram_rdata;
          end
          if (!posf && newent[DL_LSB +: TB] <= ram_rdata[DL_LSB +: TB]) begin
            posf <= 1'b1;
            pos <= idx;
          end
          if (!rf && ram_rdata[1:0] == dmtt_pkg::RS_READY) begin
            rf <= 1'b1;
            rk <= idx;
            rkdata <= ram_rdata;
          end
          if (idx == cur_slot) begin
            curdata <= ram_rdata;
          end
          if (CW'(idx) + CW'(1) == n) begin
            state <= S_DECIDE;
          end else begin
            idx <= idx + IW'(1);
            state <= S_SCANRD;
          end
        end
        S_DECIDE: begin
          state <= S_DONE;
          case (act)
            dmtt_pkg::ACT_REG, dmtt_pkg::ACT_REG_RM: begin
              if ((act == dmtt_pkg::ACT_REG_RM && per_raw != dl_raw) || per_raw == '0) begin
                status <= dmtt_pkg::STAT_INVALID;
              end else if (found) begin
                status <= dmtt_pkg::STAT_DUP;
              end else if (n == CW'(MAX_TASKS)) begin
                status <= dmtt_pkg::STAT_FULL;
              end else begin
                if (!posf) pos <= n[IW-1:0];
                oi <= '0;
                run <= '0;
                state <= S_OIRD;
              end
            end
            dmtt_pkg::ACT_REMOVE: begin
              if (id == '0) begin
                status <= dmtt_pkg::STAT_INVALID;
              end else if (!found) begin
                status <= dmtt_pkg::STAT_NOTFOUND;
              end else begin
                if (cur_valid) begin
                  if (cur_slot == fk) begin
                    cur_valid <= 1'b0;
                    cur_slot <= '0;
                    cur_ident <= '0;
                  end else if (cur_slot > fk) begin
                    cur_slot <= cur_slot - IW'(1);
                  end
                end
                sidx <= fk;
                sh_up <= 1'b0;
                state <= S_SHCHK;
              end
            end
            dmtt_pkg::ACT_YIELD: begin
              if (!found) begin
                status <= dmtt_pkg::STAT_NOTFOUND;
              end else begin
                wa <= fk;
                wd <= {fdata[EW-1:2], dmtt_pkg::RS_SLEEP};
                state <= S_WRITE;
                if (cur_valid && cur_slot == fk) begin
                  cur_valid <= 1'b0;
                  cur_slot <= '0;
                  cur_ident <= '0;
                end
              end
            end
            dmtt_pkg::ACT_WAKE: begin
              if (!found) begin
                status <= dmtt_pkg::STAT_NOTFOUND;
              end else if (fdata[1:0] == dmtt_pkg::RS_SLEEP) begin
                wa <= fk;
                wd <= {fdata[EW-1:2], dmtt_pkg::RS_READY};
                state <= S_WRITE;
              end
            end
            dmtt_pkg::ACT_DISPATCH: begin
              if (!rf) begin
                status <= dmtt_pkg::STAT_NOTHING;
              end else if (cur_valid &&
                           curdata[DL_LSB +: TB] < rkdata[DL_LSB +: TB]) begin
                status <= dmtt_pkg::STAT_OK;
              end else begin
                if (cur_valid) begin
                  wa <= cur_slot;
                  wd <= {curdata[EW-1:2], dmtt_pkg::RS_READY};
                  wa2 <= rk;
                  wd2 <= {rkdata[EW-1:2], dmtt_pkg::RS_RUNNING};
                  has2 <= 1'b1;
                  preempted_valid <= 1'b1;
                  preempted_id <= cur_ident;
                end else begin
                  wa <= rk;
                  wd <= {rkdata[EW-1:2], dmtt_pkg::RS_RUNNING};
                end
                cur_valid <= 1'b1;
                cur_slot <= rk;
                cur_ident <= rkdata[ID_LSB +: IDB];
                switched <= 1'b1;
                state <= S_WRITE;
              end
            end
            default: status <= dmtt_pkg::STAT_INVALID;
          endcase
        end
        S_OIRD: state <= S_OIEV;
        S_OIEV: begin
          ci <= oient[CO_LSB +: TB];
          di <= oient[DL_LSB +: TB];
          tt <= sat1(DW'(run) + DW'(oient[CO_LSB +: TB]));
          state <= S_ITER;
        end
        S_ITER: begin
          intf <= '0;
          ij <= '0;
          state <= (oi == '0) ? S_CHK : S_INRD;
        end
        S_INRD: state <= S_INEV;
        S_INEV: begin
          pj <= inent[PE_LSB +: TB];
          cj <= inent[CO_LSB +: TB];
          dq <= DW'(tt) + DW'(inent[PE_LSB +: TB]) - DW'(1);
          drem <= '0;
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (trial >= {1'b0, pj}) begin
            drem <= TB'(trial - {1'b0, pj});
            dq <= {dq[DW-2:0], 1'b1};
          end else begin
            drem <= trial[TB-1:0];
            dq <= {dq[DW-2:0], 1'b0};
          end
          dcnt <= dcnt + KW'(1);
          if (dcnt == KW'(DW - 1)) state <= S_MUL;
        end
        S_MUL: begin
          prod <= dq[TB-1:0] * cj;
          state <= S_ACC;
        end
        S_ACC: begin
          intf <= sat2((2*TB+1)'(intf) + (2*TB+1)'(prod));
          ij <= ij + IW'(1);
          state <= (ij + IW'(1) == oi) ? S_CHK : S_INRD;
        end
        S_CHK: begin
          tt <= tn;
          if (tn > di) begin
            status <= dmtt_pkg::STAT_NOSCHED;
            state <= S_DONE;
          end else if (chk_done) begin
            run <= sat1(DW'(run) + DW'(ci));
            if (CW'(oi) == n) begin
              if (cur_valid && cur_slot >= pos) cur_slot <= cur_slot + IW'(1);
              sidx <= n[IW-1:0];
              sh_up <= 1'b1;
              state <= S_SHCHK;
            end else begin
              oi <= oi + IW'(1);
              state <= S_OIRD;
            end
          end else begin
            state <= S_ITER;
          end
        end
        S_SHCHK: begin
          if (sh_up) begin
            if (sidx > pos) begin
              state <= S_SHRD;
            end else begin
              wa <= pos;
              wd <= newent;
              n <= n + CW'(1);
              state <= S_WRITE;
            end
          end else begin
            if (CW'(sidx) + CW'(1) < n) begin
              state <= S_SHRD;
            end else begin
              n <= n - CW'(1);
              state <= S_DONE;
            end
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          sidx <= sh_up ? sidx - IW'(1) : sidx + IW'(1);
          state <= S_SHCHK;
        end
        S_WRITE: begin
          if (has2) begin
            has2 <= 1'b0;
            wa <= wa2;
            wd <= wd2;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign running_valid = cur_valid;
  assign running_id = cur_valid ? cur_ident : '0;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_cur_in_table: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && state == S_IDLE) |-> (CW'(cur_slot) < n))
    else $error("running slot lies outside the used entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(MAX_TASKS))
    else $error("entry count exceeds the table depth");

  a_switch_running: assert property (@(posedge clk) disable iff (rst)
    (done && switched) |-> (running_valid && status == dmtt_pkg::STAT_OK))
    else $error("switch reported without a running task");

endmodule
